>>> hdl/ersort_pkg.sv
package ersort_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int SEQ_W = $clog2(MAX_RECORDS);
  localparam int COUNT_W = $clog2(MAX_RECORDS + 1);
  localparam int PHASE_W = $clog2(MAX_RECORDS);

  localparam int SHIFT_LONG = 22;
  localparam int SHIFT_HEAVY = 16;
  localparam int OVL_W = 32 - SHIFT_HEAVY;

  localparam logic [1:0] MODE_LABEL = 2'd0;
  localparam logic [1:0] MODE_LONG = 2'd1;
  localparam logic [1:0] MODE_HEAVY = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [31:0] key_word;
    logic [31:0] second_word;
    logic [31:0] third_word;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_key_word;
    logic [31:0] out_second_word;
    logic [31:0] out_third_word;
    logic        out_last;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key_word;
    logic [31:0] second_word;
    logic [31:0] third_word;
  } rec_t;

  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] seq;
    rec_t             rec;
  } cell_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LO,
    SEL_HI
  } cell_sel_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_t;

endpackage

>>> hdl/edge_record_sorter_core.sv
// Channel  | Direction | Handshake          | Beat contents
// cfg      | in        | cfg_valid/ready    | cfg_data: sort mode
// in       | in        | in_valid/ready     | in_item: one record and its last mark
// out      | out       | out_valid/ready    | out_item: one sorted record with flags
//
// A set of n records is loaded one record per input beat, then sorted by odd-even
// transposition over the row of cells, then emitted one record per output beat.
// The number of sort phases follows the cell count, since each phase moves a record at most one cell.
// Input is held off from the last input beat until the last output beat is taken.
// Reset empties the row and sets the sort mode to zero.
module edge_record_sorter_core
  import ersort_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_t             state;
  state_t             state_next;
  logic [1:0]         sort_mode;
  logic [COUNT_W-1:0] count;
  logic               dropped;
  logic [PHASE_W-1:0] phase;

  cell_t     cells [MAX_RECORDS];
  cell_sel_t sel [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] swap_raw;
  logic [MAX_RECORDS-1:0] swap_act;
  cell_t     new_cell;
  cell_t     empty_cell;

  logic in_fire;
  logic out_fire;
  logic has_room;
  logic sort_done;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign has_room = count < COUNT_W'(MAX_RECORDS);
  assign sort_done = phase == PHASE_W'(MAX_RECORDS - 1);

  assign new_cell.valid = 1'b1;
  assign new_cell.seq = count[SEQ_W-1:0];
  assign new_cell.rec.key_word = in_item.key_word;
  assign new_cell.rec.second_word = in_item.second_word;
  assign new_cell.rec.third_word = in_item.third_word;
  assign empty_cell = '0;

  assign swap_raw[MAX_RECORDS-1] = 1'b0;
  assign swap_act[MAX_RECORDS-1] = 1'b0;

  for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
    cell_t     lo_src;
    cell_t     hi_src;
    logic      take_hi;
    logic      take_lo;

    if (g == 0) begin : g_first
      assign lo_src = new_cell;
      assign take_lo = 1'b0;
    end else begin : g_rest
      assign lo_src = cells[g-1];
      assign take_lo = swap_act[g-1];
    end

    if (g == MAX_RECORDS - 1) begin : g_last
      assign hi_src = empty_cell;
      assign take_hi = 1'b0;
    end else begin : g_inner
      localparam logic PAR = 1'(g % 2);
      assign hi_src = cells[g+1];
      assign take_hi = swap_act[g];
      assign swap_act[g] = swap_raw[g] && (phase[0] == PAR);

      ersort_cmp u_cmp (
        .mode (sort_mode),
        .lo   (cells[g]),
        .hi   (cells[g+1]),
        .swap (swap_raw[g])
      );
    end

    always_comb begin
      sel[g] = SEL_HOLD;
      unique case (state)
        ST_LOAD: begin
          if (in_fire && has_room) begin
            sel[g] = SEL_LO;
          end
        end
        ST_SORT: begin
          if (take_hi) begin
            sel[g] = SEL_HI;
          end else if (take_lo) begin
            sel[g] = SEL_LO;
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            sel[g] = SEL_HI;
          end
        end
        default: sel[g] = SEL_HOLD;
      endcase
    end

    ersort_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .sel     (sel[g]),
      .from_lo (lo_src),
      .from_hi (hi_src),
      .cur     (cells[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && in_item.is_last) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sort_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && out_item.out_last) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_LOAD:  in_ready = 1'b1;
      ST_DRAIN: out_valid = cells[0].valid;
      default: begin
        in_ready = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_item.out_key_word = cells[0].rec.key_word;
  assign out_item.out_second_word = cells[0].rec.second_word;
  assign out_item.out_third_word = cells[0].rec.third_word;
  assign out_item.out_last = !cells[1].valid;
  assign out_item.overflow = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      sort_mode <= MODE_LABEL;
      count <= '0;
      dropped <= 1'b0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        sort_mode <= cfg_data;
      end
      if (state == ST_LOAD && in_fire) begin
        if (has_room) begin
          count <= count + COUNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (state == ST_SORT) begin
        phase <= phase + PHASE_W'(1);
      end else begin
        phase <= '0;
      end
      if (state == ST_DRAIN && out_fire && out_item.out_last) begin
        count <= '0;
        dropped <= 1'b0;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input and output open at once.");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.is_last) |=> !in_ready)
    else $error("Input still open after a last beat.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_RECORDS))
    else $error("Record count beyond capacity.");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_item.out_last) |=> (in_ready && count == '0 && !cells[0].valid))
    else $error("Set not cleared after its last output beat.");

endmodule

>>> hdl/ersort_cell.sv
module ersort_cell
  import ersort_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_sel_t sel,
  input  cell_t     from_lo,
  input  cell_t     from_hi,
  output cell_t     cur
);

  cell_t cur_next;

  always_comb begin
    unique case (sel)
      SEL_LO:   cur_next = from_lo;
      SEL_HI:   cur_next = from_hi;
      default:  cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    cur.seq <= cur_next.seq;
    cur.rec <= cur_next.rec;
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
  end

endmodule

>>> hdl/ersort_cmp.sv
module ersort_cmp
  import ersort_pkg::*;
(
  input  logic [1:0] mode,
  input  cell_t      lo,
  input  cell_t      hi,
  output logic       swap
);

  logic [OVL_W-1:0] lo_ovl;
  logic [OVL_W-1:0] hi_ovl;

  always_comb begin
    if (mode == MODE_LONG) begin
      lo_ovl = OVL_W'(lo.rec.third_word >> SHIFT_LONG);
      hi_ovl = OVL_W'(hi.rec.third_word >> SHIFT_LONG);
    end else begin
      lo_ovl = OVL_W'(lo.rec.third_word >> SHIFT_HEAVY);
      hi_ovl = OVL_W'(hi.rec.third_word >> SHIFT_HEAVY);
    end
  end

  // The lower cell is emitted first, so swap when it belongs strictly after its neighbor.
  // Arrival order breaks any tie left after the mode's compared fields, so records that compare equal keep their order.
  always_comb begin
    priority if (!(lo.valid && hi.valid)) begin
      swap = 1'b0;
    end else if (mode == MODE_NONE) begin
      swap = lo.seq > hi.seq;
    end else if (lo.rec.key_word != hi.rec.key_word) begin
      swap = lo.rec.key_word > hi.rec.key_word;
    end else if (mode == MODE_LABEL && lo.rec.second_word != hi.rec.second_word) begin
      swap = lo.rec.second_word > hi.rec.second_word;
    end else if (mode != MODE_LABEL && lo_ovl != hi_ovl) begin
      swap = lo_ovl < hi_ovl;
    end else begin
      swap = lo.seq > hi.seq;
    end
  end

endmodule
